@@ rtl/core/cle_pkg.sv @@
// ----------------------------------------------------------------------------
// cle_pkg
// Shared types and constants of the canonical line editor: request and result
// structs, result kinds and the control characters it reacts to.
// ----------------------------------------------------------------------------
package cle_pkg;

	localparam int DEFAULT_LINE_DEPTH = 64;

	// Result kinds
	localparam logic [1:0] KIND_ECHO  = 2'd0;
	localparam logic [1:0] KIND_LINE  = 2'd1;
	localparam logic [1:0] KIND_EMPTY = 2'd2;
	localparam logic [1:0] KIND_DROP  = 2'd3;

	// Request actions
	localparam logic ACT_CHAR = 1'b0;
	localparam logic ACT_TAKE = 1'b1;

	// Control characters
	localparam logic [7:0] CH_CR  = 8'h0D;
	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_BS  = 8'h08;
	localparam logic [7:0] CH_DEL = 8'h7F;
	localparam logic [7:0] CH_SP  = 8'h20;

	typedef struct packed {
		logic       action;
		logic [7:0] char_in;
		logic [6:0] max_bytes;
	} in_item_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data_byte;
		logic       last;
		logic       line_ready_now;
	} out_item_t;

endpackage

@@ rtl/core/canonical_line_editor.sv @@
// ----------------------------------------------------------------------------
// canonical_line_editor
// Terminal line editor: stores, erases and echoes received characters and
// streams a completed line out of the line store on a take request.
// ----------------------------------------------------------------------------
// Results: a character or empty take has its first result registered as the
// request is accepted; a line take first enters the take state, which reads
// the store and loads the output slot together. A character gives one to
// three results (one per echo byte); a take gives one empty result, or else
// min(fill, max_bytes) line bytes from the store's single read port, one per
// cycle while taken. The next request is accepted once the last result is out.
// Reset: fill count, ready flag, sequencer and output valid clear at once; the
// line store is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module canonical_line_editor #(
	parameter int LINE_DEPTH = cle_pkg::DEFAULT_LINE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  cle_pkg::in_item_t  in_item,
	output logic               out_valid,
	input  logic               out_ready,
	output cle_pkg::out_item_t out_item
);
	import cle_pkg::*;

	localparam int ADDR_W = $clog2(LINE_DEPTH);
	localparam int CNT_W  = $clog2(LINE_DEPTH + 1);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_ECHO = 3'b010,
		ST_TAKE = 3'b100
	} state_t;

	state_t            state_q, state_n;
	logic [CNT_W-1:0]  fill_q, fill_n;
	logic              ready_q, ready_n;
	logic [1:0]        echo_left_q, echo_left_n;
	logic              echo_bs_q, echo_bs_n;
	logic [ADDR_W-1:0] idx_q, idx_n;
	logic [CNT_W-1:0]  len_q, len_n;

	logic              out_vld_q;
	logic [1:0]        out_kind_q;
	logic [7:0]        out_byte_q;
	logic              out_last_q;
	logic              out_lrn_q;
	logic              out_line_q;

	logic              slot_free;
	logic              accept;
	logic              emit;
	logic [1:0]        e_kind;
	logic [7:0]        e_byte;
	logic              e_last;
	logic              e_lrn;
	logic              e_line;

	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	logic [7:0]        wr_data;
	logic              rd_en;
	logic [7:0]        rd_data;

	logic [CNT_W-1:0]  take_len;
	logic [CNT_W-1:0]  idx_next;

	cle_line_store #(
		.LINE_DEPTH(LINE_DEPTH)
	) u_store (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(idx_q),
		.rd_data(rd_data)
	);

	// Output slot frees when empty or being taken
	assign slot_free = !out_vld_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE) && slot_free;
	assign accept    = in_valid && in_ready;

	// Clip the take length to the requested count
	assign take_len = (7'(fill_q) > in_item.max_bytes) ? CNT_W'(in_item.max_bytes) : fill_q;
	assign idx_next = CNT_W'(idx_q) + CNT_W'(1);
	assign wr_addr  = fill_q[ADDR_W-1:0];

	// Sequence requests and update line state
	always_comb begin
		state_n     = state_q;
		fill_n      = fill_q;
		ready_n     = ready_q;
		echo_left_n = echo_left_q;
		echo_bs_n   = echo_bs_q;
		idx_n       = idx_q;
		len_n       = len_q;
		emit        = 1'b0;
		e_kind      = KIND_ECHO;
		e_byte      = 8'd0;
		e_last      = 1'b0;
		e_lrn       = ready_q;
		e_line      = 1'b0;
		wr_en       = 1'b0;
		wr_data     = in_item.char_in;
		rd_en       = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					emit = 1'b1;
					if (in_item.action == ACT_CHAR) begin
						if (ready_q) begin
							// drop characters while a line waits
							e_kind = KIND_DROP;
							e_last = 1'b1;
							e_lrn  = 1'b1;
						end else if (in_item.char_in == CH_CR || in_item.char_in == CH_LF) begin
							if (fill_q != CNT_W'(LINE_DEPTH)) begin
								wr_en   = 1'b1;
								wr_data = CH_LF;
								fill_n  = fill_q + CNT_W'(1);
							end
							ready_n     = 1'b1;
							e_byte      = CH_CR;
							e_lrn       = 1'b1;
							echo_left_n = 2'd1;
							echo_bs_n   = 1'b0;
							state_n     = ST_ECHO;
						end else if (in_item.char_in == CH_BS || in_item.char_in == CH_DEL) begin
							if (fill_q != '0) begin
								fill_n = fill_q - CNT_W'(1);
							end
							e_byte      = CH_BS;
							e_lrn       = 1'b0;
							echo_left_n = 2'd2;
							echo_bs_n   = 1'b1;
							state_n     = ST_ECHO;
						end else begin
							// keep one slot free for the newline
							if (fill_q < CNT_W'(LINE_DEPTH - 1)) begin
								wr_en  = 1'b1;
								fill_n = fill_q + CNT_W'(1);
							end
							e_byte = in_item.char_in;
							e_last = 1'b1;
							e_lrn  = 1'b0;
						end
					end else begin
						if (ready_q && in_item.max_bytes != 7'd0) begin
							fill_n  = '0;
							ready_n = 1'b0;
							e_lrn   = 1'b0;
							if (take_len == '0) begin
								e_kind = KIND_EMPTY;
								e_last = 1'b1;
							end else begin
								// first line byte is read and loaded in the take state
								emit    = 1'b0;
								len_n   = take_len;
								idx_n   = '0;
								state_n = ST_TAKE;
							end
						end else begin
							e_kind = KIND_EMPTY;
							e_last = 1'b1;
						end
					end
				end
			end
			ST_ECHO: begin
				if (slot_free) begin
					emit        = 1'b1;
					e_byte      = echo_bs_q ? ((echo_left_q == 2'd2) ? CH_SP : CH_BS) : CH_LF;
					e_last      = (echo_left_q == 2'd1);
					echo_left_n = echo_left_q - 2'd1;
					if (echo_left_q == 2'd1) begin
						state_n = ST_IDLE;
					end
				end
			end
			ST_TAKE: begin
				if (slot_free) begin
					// read one line byte straight into the output slot
					emit   = 1'b1;
					rd_en  = 1'b1;
					e_kind = KIND_LINE;
					e_line = 1'b1;
					e_last = (idx_next == len_q);
					idx_n  = idx_next[ADDR_W-1:0];
					if (idx_next == len_q) begin
						state_n = ST_IDLE;
					end
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	// Hold control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fill_q      <= '0;
			ready_q     <= 1'b0;
			echo_left_q <= '0;
			echo_bs_q   <= 1'b0;
			idx_q       <= '0;
			len_q       <= '0;
			out_vld_q   <= 1'b0;
		end else begin
			state_q     <= state_n;
			fill_q      <= fill_n;
			ready_q     <= ready_n;
			echo_left_q <= echo_left_n;
			echo_bs_q   <= echo_bs_n;
			idx_q       <= idx_n;
			len_q       <= len_n;
			if (slot_free) begin
				out_vld_q <= emit;
			end
		end
	end

	// Load the output slot
	always_ff @(posedge clk) begin
		if (slot_free && emit) begin
			out_kind_q <= e_kind;
			out_byte_q <= e_byte;
			out_last_q <= e_last;
			out_lrn_q  <= e_lrn;
			out_line_q <= e_line;
		end
	end

	assign out_valid               = out_vld_q;
	assign out_item.kind           = out_kind_q;
	assign out_item.data_byte      = out_line_q ? rd_data : out_byte_q;
	assign out_item.last           = out_last_q;
	assign out_item.line_ready_now = out_lrn_q;

endmodule

@@ rtl/core/cle_line_store.sv @@
// ----------------------------------------------------------------------------
// cle_line_store
// Line byte memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module cle_line_store #(
	parameter int LINE_DEPTH = cle_pkg::DEFAULT_LINE_DEPTH,
	localparam int ADDR_W    = $clog2(LINE_DEPTH)
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [7:0]        wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [7:0]        rd_data
);
	import cle_pkg::*;

	logic [7:0] mem_q [LINE_DEPTH];

	// Write stored bytes
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read; hold data when not enabled
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the canonical line editor. A scoreboard keeps its
// own line store, fill count and ready flag, predicts the echo, line, empty
// and drop results of every accepted request, and compares each result that
// leaves the block with the oldest prediction. Directed requests cover the
// corner cases. Random typed lines follow, with erasures, overlong lines, noise
// and takes of every length. Both sides idle in random bursts, and the
// receiver stalls once for a long stretch.
// ----------------------------------------------------------------------------
module tb;
	import cle_pkg::*;

	localparam int DEPTH         = DEFAULT_LINE_DEPTH;
	localparam int RANDOM_ITEMS  = 480;
	localparam int CYCLE_LIMIT   = 1500000;
	localparam int HOLD_CYCLES   = 400;
	localparam int DRAIN_CYCLES  = 16;

	// Mirror of the editor: predicts results and checks them in order
	class line_echo_tracker;
		logic [7:0] store_copy [DEPTH];
		int         fill;
		bit         ready;
		out_item_t  due_results [$];
		int         errors;

		function new();
			fill   = 0;
			ready  = 0;
			errors = 0;
		endfunction

		function out_item_t shape(logic [1:0] kind, logic [7:0] data);
			out_item_t r;
			r.kind           = kind;
			r.data_byte      = data;
			r.last           = 1'b0;
			r.line_ready_now = 1'b0;
			return r;
		endfunction

		function void note_request(in_item_t req);
			out_item_t res [$];
			int        take_len;
			if (req.action == ACT_CHAR) begin
				if (ready) begin
					// drop characters while a line waits
					res.push_back(shape(KIND_DROP, 8'h00));
				end else if (req.char_in == CH_CR || req.char_in == CH_LF) begin
					if (fill < DEPTH) begin
						store_copy[fill] = CH_LF;
						fill++;
					end
					ready = 1;
					res.push_back(shape(KIND_ECHO, CH_CR));
					res.push_back(shape(KIND_ECHO, CH_LF));
				end else if (req.char_in == CH_BS || req.char_in == CH_DEL) begin
					if (fill > 0)
						fill--;
					res.push_back(shape(KIND_ECHO, CH_BS));
					res.push_back(shape(KIND_ECHO, CH_SP));
					res.push_back(shape(KIND_ECHO, CH_BS));
				end else begin
					// keep the last slot for the newline
					if (fill < DEPTH - 1) begin
						store_copy[fill] = req.char_in;
						fill++;
					end
					res.push_back(shape(KIND_ECHO, req.char_in));
				end
			end else begin
				if (ready && req.max_bytes != 0) begin
					take_len = fill;
					if (take_len > req.max_bytes)
						take_len = req.max_bytes;
					for (int i = 0; i < take_len; i++)
						res.push_back(shape(KIND_LINE, store_copy[i]));
					fill  = 0;
					ready = 0;
					if (res.size() == 0)
						res.push_back(shape(KIND_EMPTY, 8'h00));
				end else begin
					res.push_back(shape(KIND_EMPTY, 8'h00));
				end
			end
			// mark the flag and the final result, then queue
			foreach (res[i]) begin
				res[i].line_ready_now = ready;
				res[i].last           = (i == res.size() - 1);
				due_results.push_back(res[i]);
			end
		endfunction

		function void check_result(out_item_t got);
			out_item_t want;
			if (due_results.size() == 0) begin
				$error("unexpected result: kind %0d data_byte %h", got.kind, got.data_byte);
				errors++;
				return;
			end
			want = due_results.pop_front();
			if (got.kind !== want.kind) begin
				$error("kind: expected %0d, actual %0d", want.kind, got.kind);
				errors++;
			end
			if (got.data_byte !== want.data_byte) begin
				$error("data_byte: expected %h, actual %h", want.data_byte, got.data_byte);
				errors++;
			end
			if (got.last !== want.last) begin
				$error("last: expected %0d, actual %0d", want.last, got.last);
				errors++;
			end
			if (got.line_ready_now !== want.line_ready_now) begin
				$error("line_ready_now: expected %0d, actual %0d",
					want.line_ready_now, got.line_ready_now);
				errors++;
			end
		endfunction
	endclass

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_item_t  in_item;
	logic      out_valid;
	logic      out_ready;
	out_item_t out_item;

	line_echo_tracker tracker;
	int  sent_count;
	int  cycle_count;
	int  idle_odds;     // 0 = no idling, else idle one time in idle_odds
	bit  hold_req;
	bit  hold_done;

	canonical_line_editor dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	always #5 clk = ~clk;

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Note accepted requests, then check accepted results
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				tracker.note_request(in_item);
			if (out_valid && out_ready)
				tracker.check_result(out_item);
		end
	end

	function automatic bit idle_now();
		return idle_odds != 0 && $urandom_range(0, idle_odds - 1) == 0;
	endfunction

	// Offer one request, optionally after an idle burst, and hold until accepted
	task automatic send_request(input in_item_t req);
		if (idle_now()) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_item  <= req;
		do @(posedge clk); while (!in_ready);
		sent_count++;
	endtask

	task automatic send_char(input logic [7:0] c);
		in_item_t req;
		req.action    = ACT_CHAR;
		req.char_in   = c;
		req.max_bytes = 7'($urandom);
		send_request(req);
	endtask

	task automatic send_take(input logic [6:0] n);
		in_item_t req;
		req.action    = ACT_TAKE;
		req.char_in   = 8'($urandom);
		req.max_bytes = n;
		send_request(req);
	endtask

	function automatic logic [7:0] pick_plain();
		logic [7:0] c;
		do c = 8'($urandom_range(0, 255));
		while (c == CH_CR || c == CH_LF || c == CH_BS || c == CH_DEL);
		return c;
	endfunction

	// Type one line with random erasures, end it, then take it
	task automatic type_and_take();
		int len;
		if ($urandom_range(0, 11) == 0)
			len = $urandom_range(55, 70);
		else
			len = $urandom_range(0, 8);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 7) == 0)
				send_char($urandom_range(0, 1) ? CH_BS : CH_DEL);
			else
				send_char(pick_plain());
		end
		send_char($urandom_range(0, 1) ? CH_CR : CH_LF);
		if ($urandom_range(0, 3) == 0) begin
			repeat ($urandom_range(1, 2)) send_char(8'($urandom_range(0, 255)));
		end
		if ($urandom_range(0, 5) == 0)
			send_take(7'd0);
		if ($urandom_range(0, 5) == 0)
			send_take(7'($urandom_range(65, 127)));
		else
			send_take(7'($urandom_range(1, 64)));
	endtask

	// Receiver: random stall bursts, one long hold-off on request
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				hold_req = 0;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (idle_now()) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 7)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// Main sequence
	initial begin
		clk         = 1'b0;
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		in_item     = '0;
		sent_count  = 0;
		cycle_count = 0;
		idle_odds   = 4;
		hold_req    = 0;
		hold_done   = 0;
		tracker     = new();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty take, erase on empty, byte extremes, drops, truncation
		send_take(7'd5);
		send_char(CH_BS);
		send_char(CH_DEL);
		send_char(8'h00);
		send_char(8'hFF);
		send_char(8'h61);
		send_char(CH_DEL);
		send_char(8'h80);
		send_char(CH_BS);
		send_char(8'h7E);
		send_char(CH_CR);
		send_char(8'h41);
		send_char(CH_LF);
		send_take(7'd0);
		send_take(7'd127);
		send_char(8'h78);
		send_char(8'h55);
		send_char(CH_LF);
		send_take(7'd1);
		send_take(7'd1);
		send_char(8'h2A);
		send_char(CH_CR);
		send_take(7'd64);

		// Random lines and noise
		while (sent_count < RANDOM_ITEMS) begin
			if (sent_count > 150 && !hold_done) begin
				hold_req  = 1;
				hold_done = 1;
			end
			if (sent_count >= 220 && sent_count < 280)
				idle_odds = 0;
			else if (sent_count >= 400)
				idle_odds = 0;
			else
				idle_odds = (sent_count % 3 == 0) ? 2 : 4;
			if ($urandom_range(0, 9) < 7)
				type_and_take();
			else
				send_request(in_item_t'(16'($urandom)));
		end
		in_valid <= 1'b0;

		// Drain
		while (tracker.due_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (tracker.errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
